// ===== design/response_frame_checker_macros.svh =====
// Assertion macros for the response frame checker
`ifndef RESPONSE_FRAME_CHECKER_MACROS_SVH
`define RESPONSE_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfc assertion failed");

// Next-cycle implication, checked outside reset
`define RFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfc assertion failed");

`endif

// ===== design/rfc_pkg.sv =====
// Types and constants shared by the response frame checker
`default_nettype none
package rfc_pkg;

  localparam logic [7:0] SYNC_FIRST   = 8'hED;
  localparam logic [7:0] SYNC_SECOND  = 8'hFA;
  localparam int         COUNT_W      = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W:0]   MIN_FRAME    = 10'd5;
  localparam logic [COUNT_W:0]   LEN_OVERHEAD = 10'd3;

  localparam logic [COUNT_W-1:0] POS_SYNC_FIRST  = 9'd0;
  localparam logic [COUNT_W-1:0] POS_SYNC_SECOND = 9'd1;
  localparam logic [COUNT_W-1:0] POS_LENGTH      = 9'd2;
  localparam logic [COUNT_W-1:0] POS_ADDRESS     = 9'd3;
  localparam logic [COUNT_W-1:0] POS_PAYLOAD     = 9'd4;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_HEADER = 2'd1,
    STATUS_LENGTH = 2'd2,
    STATUS_SUM    = 2'd3
  } status_t;

  typedef struct packed {
    kind_t      item_kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_address;
    status_t    frame_status;
  } result_t;

endpackage
`default_nettype wire

// ===== design/rfc_if.sv =====
// Valid/ready channel interfaces for received bytes and checker results
`default_nettype none
interface rfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface rfc_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] payload_byte;
  logic [7:0] frame_address;
  logic [1:0] frame_status;

  modport source (output valid, output item_kind, output payload_byte,
                  output frame_address, output frame_status, input ready);
  modport sink (input valid, input item_kind, input payload_byte,
                input frame_address, input frame_status, output ready);
endinterface
`default_nettype wire

// ===== design/rfc_core.sv =====
// Frame state tracking and per-byte result generation
`default_nettype none
module rfc_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            byte_fire,
  input  wire logic [7:0]      rx_byte,
  input  wire logic            last_byte,
  output logic                 res_valid,
  output rfc_pkg::result_t     res
);

  logic [rfc_pkg::COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]                  running_sum_r, running_sum_nxt;
  logic                        header_good_r, header_good_nxt;
  logic [7:0]                  length_field_r, length_field_nxt;
  logic [7:0]                  address_field_r, address_field_nxt;

  logic [rfc_pkg::COUNT_W:0]   total;
  logic [rfc_pkg::COUNT_W:0]   expected_total;
  logic [rfc_pkg::COUNT_W:0]   payload_end;
  logic                        in_payload;
  rfc_pkg::status_t            status;

  always_comb begin
    header_good_nxt   = header_good_r;
    length_field_nxt  = length_field_r;
    address_field_nxt = address_field_r;
    if (byte_count_r == rfc_pkg::POS_SYNC_FIRST && rx_byte != rfc_pkg::SYNC_FIRST) begin
      header_good_nxt = 1'b0;
    end
    if (byte_count_r == rfc_pkg::POS_SYNC_SECOND && rx_byte != rfc_pkg::SYNC_SECOND) begin
      header_good_nxt = 1'b0;
    end
    if (byte_count_r == rfc_pkg::POS_LENGTH) begin
      length_field_nxt = rx_byte;
    end
    if (byte_count_r == rfc_pkg::POS_ADDRESS) begin
      address_field_nxt = rx_byte;
    end

    total          = {1'b0, byte_count_r} + 10'd1;
    expected_total = {2'b00, length_field_nxt} + rfc_pkg::LEN_OVERHEAD;
    payload_end    = {2'b00, length_field_nxt} + 10'd1;
    in_payload     = header_good_nxt && (byte_count_r >= rfc_pkg::POS_PAYLOAD)
                     && ({1'b0, byte_count_r} <= payload_end);

    priority if (total < rfc_pkg::MIN_FRAME || !header_good_nxt) begin
      status = rfc_pkg::STATUS_HEADER;
    end else if (total != expected_total) begin
      status = rfc_pkg::STATUS_LENGTH;
    end else if (running_sum_r != rx_byte) begin
      status = rfc_pkg::STATUS_SUM;
    end else begin
      status = rfc_pkg::STATUS_OK;
    end

    running_sum_nxt = running_sum_r + rx_byte;
    byte_count_nxt  = (byte_count_r == rfc_pkg::COUNT_MAX) ? byte_count_r
                                                           : byte_count_r + 9'd1;

    res_valid = byte_fire && (last_byte || in_payload);
    if (last_byte) begin
      res.item_kind     = rfc_pkg::KIND_VERDICT;
      res.payload_byte  = 8'd0;
      res.frame_address = address_field_nxt;
      res.frame_status  = status;
    end else begin
      res.item_kind     = rfc_pkg::KIND_PAYLOAD;
      res.payload_byte  = rx_byte;
      res.frame_address = 8'd0;
      res.frame_status  = rfc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= '0;
      running_sum_r   <= '0;
      header_good_r   <= 1'b1;
      length_field_r  <= '0;
      address_field_r <= '0;
    end else if (byte_fire) begin
      if (last_byte) begin
        byte_count_r    <= '0;
        running_sum_r   <= '0;
        header_good_r   <= 1'b1;
        length_field_r  <= '0;
        address_field_r <= '0;
      end else begin
        byte_count_r    <= byte_count_nxt;
        running_sum_r   <= running_sum_nxt;
        header_good_r   <= header_good_nxt;
        length_field_r  <= length_field_nxt;
        address_field_r <= address_field_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/response_frame_checker.sv =====
// Top level of the response frame checker: byte tracking and result register
// Usage:
//   in_chan carries one received byte per item (rx_byte) with last_byte set on
//   the final byte of a buffer. out_chan returns zero or one item per byte:
//   a payload byte (item_kind 0) for bytes at positions 4 to length+1 while the
//   header matches, or a verdict (item_kind 1) with address and status on the
//   last byte. Payload is not held back; drop it when the verdict is an error.
//   Each result is registered before it appears on out_chan.
//   Throughput: one byte per cycle while the skid entry is empty; the frame
//   state updates per byte; results go into a two-entry output register pair.
//   Reset clears the frame state and empties the output registers; in_chan
//   ready is high whenever the skid entry is empty, so it is high after reset.
//   When the receiver stalls, the result register holds and a second skid
//   entry takes one more result; in_chan ready then drops until out_chan
//   drains. After a verdict the state returns to its reset values.
`default_nettype none
`include "response_frame_checker_macros.svh"
module response_frame_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  rfc_in_if.sink    in_chan,
  rfc_out_if.source out_chan
);

  logic              in_fire;
  logic              out_fire;
  logic              res_valid;
  rfc_pkg::result_t  res;

  rfc_pkg::result_t  main_r, main_nxt;
  logic              main_v_r, main_v_nxt;
  rfc_pkg::result_t  skid_r, skid_nxt;
  logic              skid_v_r, skid_v_nxt;

  assign in_chan.ready = !skid_v_r;
  assign in_fire       = in_chan.valid && !skid_v_r;
  assign out_fire      = main_v_r && out_chan.ready;

  rfc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_fire),
    .rx_byte   (in_chan.rx_byte),
    .last_byte (in_chan.last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    main_nxt   = main_r;
    main_v_nxt = main_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (out_fire || !main_v_r) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = res;
        main_v_nxt = res_valid;
      end
    end else if (res_valid) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_chan.valid         = main_v_r;
  assign out_chan.item_kind     = main_r.item_kind;
  assign out_chan.payload_byte  = main_r.payload_byte;
  assign out_chan.frame_address = main_r.frame_address;
  assign out_chan.frame_status  = main_r.frame_status;

  `RFC_ASSERT_NOW(a_skid_behind_main, clk, rst_n, skid_v_r, main_v_r)
  `RFC_ASSERT_NOW(a_last_gives_verdict, clk, rst_n, in_fire && in_chan.last_byte,
                  res_valid && res.item_kind == rfc_pkg::KIND_VERDICT)
  `RFC_ASSERT_NEXT(a_result_kept, clk, rst_n, res_valid, main_v_r)

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for response_frame_checker: queue-fed byte driver, predictor and result checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } rx_item_t;

  logic clk;
  logic rst_n;

  rfc_in_if  in_ch ();
  rfc_out_if out_ch ();

  response_frame_checker u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  rx_item_t          rx_bytes_q[$];
  rfc_pkg::result_t  byte_verdict_q[$];
  rx_item_t          nxt_item;
  rfc_pkg::result_t  want_item;
  int       mismatches;
  int       idle_pct;
  int       stall_pct;
  int       phase_bytes;
  int       idle_tab[4]  = '{0, 88, 0, 22};
  int       stall_tab[4] = '{0, 0, 88, 22};

  logic [rfc_pkg::COUNT_W-1:0] seen_cnt;
  logic [7:0]         run_sum;
  logic               hdr_match;
  logic [7:0]         frame_len;
  logic [7:0]         frame_addr;

  function automatic void clear_frame();
    seen_cnt   = '0;
    run_sum    = '0;
    hdr_match  = 1'b1;
    frame_len  = '0;
    frame_addr = '0;
  endfunction

  function automatic void track_byte(logic [7:0] b, logic last);
    logic [rfc_pkg::COUNT_W-1:0] pos;
    logic [rfc_pkg::COUNT_W:0]   total;
    rfc_pkg::result_t            r;
    pos = seen_cnt;
    if (pos == rfc_pkg::POS_SYNC_FIRST && b != rfc_pkg::SYNC_FIRST) hdr_match = 1'b0;
    if (pos == rfc_pkg::POS_SYNC_SECOND && b != rfc_pkg::SYNC_SECOND) hdr_match = 1'b0;
    if (pos == rfc_pkg::POS_LENGTH) frame_len = b;
    if (pos == rfc_pkg::POS_ADDRESS) frame_addr = b;
    if (last) begin
      total = {1'b0, pos} + 10'd1;
      r.item_kind     = rfc_pkg::KIND_VERDICT;
      r.payload_byte  = '0;
      r.frame_address = frame_addr;
      if (total < rfc_pkg::MIN_FRAME || !hdr_match) r.frame_status = rfc_pkg::STATUS_HEADER;
      else if (total != {2'b00, frame_len} + rfc_pkg::LEN_OVERHEAD)
        r.frame_status = rfc_pkg::STATUS_LENGTH;
      else if (run_sum != b) r.frame_status = rfc_pkg::STATUS_SUM;
      else r.frame_status = rfc_pkg::STATUS_OK;
      byte_verdict_q = {byte_verdict_q, r};
      clear_frame();
    end else begin
      run_sum = run_sum + b;
      if (seen_cnt != rfc_pkg::COUNT_MAX) seen_cnt = seen_cnt + 1'b1;
      if (hdr_match && pos >= rfc_pkg::POS_PAYLOAD
          && {1'b0, pos} <= {2'b00, frame_len} + 10'd1) begin
        r.item_kind     = rfc_pkg::KIND_PAYLOAD;
        r.payload_byte  = b;
        r.frame_address = '0;
        r.frame_status  = rfc_pkg::STATUS_OK;
        byte_verdict_q = {byte_verdict_q, r};
      end
    end
  endfunction

  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  task automatic push_rx(logic [7:0] b, logic last);
    rx_item_t it;
    it.b    = b;
    it.last = last;
    rx_bytes_q = {rx_bytes_q, it};
    phase_bytes++;
  endtask

  task automatic add_frame(logic [7:0] sync0, logic [7:0] sync1, logic [7:0] len,
                           logic [7:0] addr, int npay, int fill, logic [7:0] sum_flip);
    logic [7:0] sum;
    logic [7:0] b;
    sum = sync0 + sync1 + len + addr;
    push_rx(sync0, 1'b0);
    push_rx(sync1, 1'b0);
    push_rx(len, 1'b0);
    push_rx(addr, 1'b0);
    for (int i = 0; i < npay; i++) begin
      b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      sum = sum + b;
      push_rx(b, 1'b0);
    end
    push_rx(sum ^ sum_flip, 1'b1);
  endtask

  task automatic add_random_buffer();
    int         r;
    int         n;
    int         len;
    int         npay;
    logic [7:0] s0;
    logic [7:0] s1;
    logic [7:0] b;
    r  = $urandom_range(99);
    s0 = rfc_pkg::SYNC_FIRST;
    s1 = rfc_pkg::SYNC_SECOND;
    if (r < 65) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(2, 60) : $urandom_range(2, 10);
      add_frame(s0, s1, 8'(len), 8'($urandom_range(255)), len - 2, -1, 8'h00);
    end else if (r < 75) begin
      len = $urandom_range(2, 12);
      add_frame(s0, s1, 8'(len), 8'($urandom_range(255)), len - 2, -1,
                8'($urandom_range(1, 255)));
    end else if (r < 85) begin
      len  = $urandom_range(0, 20);
      npay = $urandom_range(0, 20);
      if (npay == len - 2) npay++;
      add_frame(s0, s1, 8'(len), 8'($urandom_range(255)), npay, -1, 8'h00);
    end else if (r < 92) begin
      len = $urandom_range(2, 10);
      if ($urandom_range(1) == 0) s0 = s0 ^ (8'h01 << $urandom_range(7));
      else s1 = s1 ^ (8'h01 << $urandom_range(7));
      add_frame(s0, s1, 8'(len), 8'($urandom_range(255)), len - 2, -1, 8'h00);
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(255));
        if ($urandom_range(1) == 0 && i == 0) b = rfc_pkg::SYNC_FIRST;
        if ($urandom_range(1) == 0 && i == 1) b = rfc_pkg::SYNC_SECOND;
        push_rx(b, i == n - 1);
      end
    end
  endtask

  task automatic drain_rx();
    while (rx_bytes_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      clear_frame();
    end else begin
      if (in_ch.valid && in_ch.ready) track_byte(in_ch.rx_byte, in_ch.last_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt_item = rx_bytes_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.rx_byte   <= nxt_item.b;
          in_ch.last_byte <= nxt_item.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (byte_verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item kind %0h payload %0h address %0h status %0h", $time,
                   out_ch.item_kind, out_ch.payload_byte, out_ch.frame_address,
                   out_ch.frame_status);
        end else begin
          want_item = byte_verdict_q.pop_front();
          cmp_field("item_kind", 8'(want_item.item_kind), 8'(out_ch.item_kind));
          cmp_field("payload_byte", want_item.payload_byte, out_ch.payload_byte);
          cmp_field("frame_address", want_item.frame_address, out_ch.frame_address);
          cmp_field("frame_status", 8'(want_item.frame_status), 8'(out_ch.frame_status));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.rx_byte   = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    mismatches      = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    phase_bytes     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    push_rx(rfc_pkg::SYNC_FIRST, 1'b1);
    add_frame(rfc_pkg::SYNC_FIRST, rfc_pkg::SYNC_SECOND, 8'd2, 8'hFF, 0, -1, 8'h00);
    add_frame(rfc_pkg::SYNC_FIRST, rfc_pkg::SYNC_SECOND, 8'd3, 8'h00, 1, 8'h00, 8'h00);
    add_frame(rfc_pkg::SYNC_FIRST, rfc_pkg::SYNC_SECOND, 8'd3, 8'h5A, 1, 8'hFF, 8'h01);
    add_frame(rfc_pkg::SYNC_FIRST, rfc_pkg::SYNC_SECOND, 8'd4, 8'h12, 1, -1, 8'h00);
    add_frame(8'h00, rfc_pkg::SYNC_SECOND, 8'd2, 8'h33, 0, -1, 8'h00);
    drain_rx();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct    = idle_tab[ph];
      stall_pct   = stall_tab[ph];
      if (ph == 1)
        add_frame(rfc_pkg::SYNC_FIRST, rfc_pkg::SYNC_SECOND, 8'd255,
                  8'($urandom_range(255)), 253, -1, 8'h00);
      if (ph == 2)
        add_frame(rfc_pkg::SYNC_FIRST, rfc_pkg::SYNC_SECOND, 8'($urandom_range(255)),
                  8'($urandom_range(255)), 515, -1, 8'h00);
      phase_bytes = 0;
      while (phase_bytes < 180) add_random_buffer();
      drain_rx();
    end

    while (rx_bytes_q.size() != 0 || in_ch.valid || byte_verdict_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/rfc_pkg.sv
design/rfc_if.sv
design/rfc_core.sv
design/response_frame_checker.sv
tb/sv/tb.sv
